// ===== rtl/go_back_n_arq_link_control_defines.svh =====
// Assertion macros shared by the link control RTL.
`ifndef GO_BACK_N_ARQ_LINK_CONTROL_DEFINES_SVH
`define GO_BACK_N_ARQ_LINK_CONTROL_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under synchronous reset.
`define GBNL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
// Next-cycle implication under synchronous reset.
`define GBNL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define GBNL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GBNL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/gbnl_pkg.sv =====
package gbnl_pkg;

   localparam int WINDOW_MAX_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CMD_RX_HDR  = 2'd0;
   localparam logic [1:0] CMD_TX_DATA = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   localparam logic [2:0] ACT_DELIVER = 3'd0;
   localparam logic [2:0] ACT_CONTROL = 3'd1;
   localparam logic [2:0] ACT_SEND    = 3'd2;
   localparam logic [2:0] ACT_RESEND  = 3'd3;
   localparam logic [2:0] ACT_REFUSE  = 3'd4;

   localparam logic [7:0] CTL_PSH = 8'h01;
   localparam logic [7:0] CTL_REQ = 8'h04;
   localparam logic [7:0] CTL_SYN = 8'h08;

   localparam logic [2:0] REG_LOCAL_PORT  = 3'd0;
   localparam logic [2:0] REG_WINDOW_SIZE = 3'd1;
   localparam logic [2:0] REG_RESEND_TO   = 3'd2;
   localparam logic [2:0] REG_EXPIRE_TO   = 3'd3;
   localparam logic [2:0] REG_INIT_SEND   = 3'd4;
   localparam logic [2:0] REG_INIT_RECV   = 3'd5;

   localparam logic [4:0]  WINDOW_SIZE_RST = 5'd4;
   localparam logic [23:0] RESEND_TO_RST   = 24'd10;
   localparam logic [23:0] EXPIRE_TO_RST   = 24'd100;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  rx_port;
      logic [15:0] rx_nonce;
      logic [7:0]  rx_control;
      logic [15:0] tx_handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] out_nonce;
      logic [7:0]  out_control;
      logic [15:0] out_handle;
      logic        window_full;
      logic [31:0] resend_total;
      logic [31:0] expired_total;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic hdr_syn;
      logic emit_deliver;
      logic emit_req;
      logic emit_synreply;
      logic ack;
      logic tx_data;
      logic tick;
      logic exp_pop;
      logic rs_emit;
      logic last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] command;
      logic       port_match;
      logic       psh;
      logic       req;
      logic       syn;
      logic       nonce_match;
      logic       out_of_range;
      logic       ring_empty;
      logic       expire_due;
      logic       resend_due;
      logic       rs_final;
   } dp_status_type;

endpackage

// ===== rtl/gbnl_ram.sv =====
module gbnl_ram
   import gbnl_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gbnl_ctrl.sv =====
module gbnl_ctrl
   import gbnl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_PSH_DLV  = 4'd2;
   localparam logic [3:0] S_PSH_REQ  = 4'd3;
   localparam logic [3:0] S_REQ      = 4'd4;
   localparam logic [3:0] S_EXP_ADDR = 4'd5;
   localparam logic [3:0] S_EXP_CHK  = 4'd6;
   localparam logic [3:0] S_RS_ADDR  = 4'd7;
   localparam logic [3:0] S_RS_EMIT  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.command)
               CMD_RX_HDR: begin
                  if (!status.port_match) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.hdr_syn = status.syn;
                     priority if (status.psh) state_in = S_PSH_DLV;
                     else if (status.req)     state_in = S_REQ;
                     else                     state_in = S_IDLE;
                  end
               end
               CMD_TX_DATA: begin
                  cmd.tx_data = 1'b1;
                  cmd.last    = 1'b1;
                  state_in    = S_IDLE;
               end
               CMD_TICK: begin
                  cmd.tick = 1'b1;
                  state_in = S_EXP_ADDR;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PSH_DLV: begin
            cmd.emit_deliver = status.nonce_match;
            state_in         = S_PSH_REQ;
         end
         S_PSH_REQ: begin
            cmd.emit_req = 1'b1;
            cmd.last     = !(status.req && status.out_of_range);
            state_in     = status.req ? S_REQ : S_IDLE;
         end
         S_REQ: begin
            if (status.out_of_range) begin
               cmd.emit_synreply = 1'b1;
               cmd.last          = 1'b1;
            end else begin
               cmd.ack = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_EXP_ADDR: begin
            state_in = status.ring_empty ? S_IDLE : S_EXP_CHK;
         end
         S_EXP_CHK: begin
            priority if (status.expire_due) begin
               cmd.exp_pop = 1'b1;
               state_in    = S_EXP_ADDR;
            end else if (status.resend_due) begin
               state_in = S_RS_ADDR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RS_ADDR: state_in = S_RS_EMIT;
         S_RS_EMIT: begin
            cmd.rs_emit = 1'b1;
            cmd.last    = status.rs_final;
            state_in    = status.rs_final ? S_IDLE : S_RS_ADDR;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/gbnl_dpath.sv =====
module gbnl_dpath
   import gbnl_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [CSR_DATA_W-1:0] csr_rdata
);

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
   localparam int EW    = (CNT_W > 5) ? CNT_W : 5;
   localparam int CMP_W = (TIME_BITS > 24) ? TIME_BITS : 24;
   localparam int SLOT_W = 16 + TIME_BITS;

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(WINDOW_MAX)) s = s - SUM_W'(WINDOW_MAX);
      return s[IDX_W-1:0];
   endfunction

   // configuration
   logic [7:0]  local_port_ff, local_port_in;
   logic [4:0]  window_size_ff, window_size_in;
   logic [23:0] resend_to_ff, resend_to_in;
   logic [23:0] expire_to_ff, expire_to_in;
   logic [15:0] init_send_ff, init_send_in;
   logic [15:0] init_recv_ff, init_recv_in;

   // link state
   req_type              req_ff, req_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [15:0]          send_base_ff, send_base_in;
   logic [15:0]          send_next_ff, send_next_in;
   logic [15:0]          expected_ff, expected_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rs_idx_ff, rs_idx_in;
   logic [31:0]          resend_cnt_ff, resend_cnt_in;
   logic [31:0]          expired_cnt_ff, expired_cnt_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // slot memories
   logic                 slot_we, last_we;
   logic [IDX_W-1:0]     slot_waddr, last_waddr, rd_addr;
   logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
   logic [TIME_BITS-1:0] last_rdata;

   logic [EW-1:0]        win_eff;
   logic [15:0]          diff;
   logic [CNT_W-1:0]     ack_k;
   logic [TIME_BITS-1:0] exp_age, rs_age;
   logic                 full_now;

   gbnl_ram #(.WIDTH(SLOT_W), .DEPTH(WINDOW_MAX)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (rd_addr),
      .rd_data (slot_rdata)
   );

   gbnl_ram #(.WIDTH(TIME_BITS), .DEPTH(WINDOW_MAX)) u_last_ram (
      .clock   (clock),
      .wr_en   (last_we),
      .wr_addr (last_waddr),
      .wr_data (now_ff),
      .rd_addr (rd_addr),
      .rd_data (last_rdata)
   );

   always_comb begin
      priority if (window_size_ff == 5'd0)             win_eff = EW'(1);
      else if (EW'(window_size_ff) > EW'(WINDOW_MAX))  win_eff = EW'(WINDOW_MAX);
      else                                             win_eff = EW'(window_size_ff);
   end

   assign full_now = (EW'(count_ff) >= win_eff);
   assign rd_addr  = wrap_add(head_ff, rs_idx_ff);
   assign diff     = req_ff.rx_nonce - send_base_ff;
   assign ack_k    = (diff < 16'(count_ff)) ? CNT_W'(diff) : count_ff;
   assign exp_age  = now_ff - slot_rdata[TIME_BITS-1:0];
   assign rs_age   = now_ff - last_rdata;

   always_comb begin
      status.command      = req_ff.command;
      status.port_match   = (req_ff.rx_port == local_port_ff);
      status.psh          = ((req_ff.rx_control & CTL_PSH) != 8'd0);
      status.req          = ((req_ff.rx_control & CTL_REQ) != 8'd0);
      status.syn          = ((req_ff.rx_control & CTL_SYN) != 8'd0);
      status.nonce_match  = (req_ff.rx_nonce == expected_ff);
      status.out_of_range = (req_ff.rx_nonce < send_base_ff) ||
                            (req_ff.rx_nonce > send_next_ff);
      status.ring_empty   = (count_ff == '0);
      status.expire_due   = (CMP_W'(exp_age) > CMP_W'(expire_to_ff));
      status.resend_due   = (CMP_W'(rs_age) > CMP_W'(resend_to_ff));
      status.rs_final     = (rs_idx_ff == count_ff - CNT_W'(1));
   end

   always_comb begin
      local_port_in  = local_port_ff;
      window_size_in = window_size_ff;
      resend_to_in   = resend_to_ff;
      expire_to_in   = expire_to_ff;
      init_send_in   = init_send_ff;
      init_recv_in   = init_recv_ff;
      req_in         = req_ff;
      now_in         = now_ff;
      send_base_in   = send_base_ff;
      send_next_in   = send_next_ff;
      expected_in    = expected_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      rs_idx_in      = rs_idx_ff;
      resend_cnt_in  = resend_cnt_ff;
      expired_cnt_in = expired_cnt_ff;
      rsp_strobe_in  = 1'b0;
      rsp_data_in    = rsp_data_ff;
      slot_we        = 1'b0;
      slot_waddr     = wrap_add(head_ff, count_ff);
      slot_wdata     = {req_ff.tx_handle, now_ff};
      last_we        = 1'b0;
      last_waddr     = wrap_add(head_ff, count_ff);

      if (cmd.load_req) req_in = req_data;
      if (cmd.hdr_syn)  expected_in = req_ff.rx_nonce;
      if (cmd.emit_deliver) expected_in = expected_ff + 16'd1;
      if (cmd.ack) begin
         head_in      = wrap_add(head_ff, ack_k);
         count_in     = count_ff - ack_k;
         send_base_in = req_ff.rx_nonce;
      end
      if (cmd.tx_data && !full_now) begin
         slot_we      = 1'b1;
         last_we      = 1'b1;
         count_in     = count_ff + CNT_W'(1);
         send_next_in = send_next_ff + 16'd1;
      end
      if (cmd.tick) begin
         now_in    = now_ff + TIME_BITS'(1);
         rs_idx_in = '0;
      end
      if (cmd.exp_pop) begin
         head_in      = wrap_add(head_ff, CNT_W'(1));
         count_in     = count_ff - CNT_W'(1);
         send_base_in = send_base_ff + 16'd1;
         if (expired_cnt_ff != '1) expired_cnt_in = expired_cnt_ff + 32'd1;
      end
      if (cmd.rs_emit) begin
         last_we    = 1'b1;
         last_waddr = rd_addr;
         rs_idx_in  = rs_idx_ff + CNT_W'(1);
         if (resend_cnt_ff != '1) resend_cnt_in = resend_cnt_ff + 32'd1;
      end

      // result build
      if (cmd.emit_deliver || cmd.emit_req || cmd.emit_synreply || cmd.tx_data ||
          cmd.rs_emit) begin
         rsp_strobe_in           = 1'b1;
         rsp_data_in.out_control = 8'd0;
         rsp_data_in.out_handle  = 16'd0;
         rsp_data_in.out_nonce   = 16'd0;
         rsp_data_in.action      = ACT_CONTROL;
         priority if (cmd.emit_deliver) begin
            rsp_data_in.action    = ACT_DELIVER;
            rsp_data_in.out_nonce = req_ff.rx_nonce;
         end else if (cmd.emit_req) begin
            rsp_data_in.out_nonce   = expected_ff;
            rsp_data_in.out_control = CTL_REQ;
         end else if (cmd.emit_synreply) begin
            rsp_data_in.out_nonce   = send_base_ff;
            rsp_data_in.out_control = CTL_SYN;
         end else if (cmd.tx_data) begin
            rsp_data_in.out_handle = req_ff.tx_handle;
            if (full_now) begin
               rsp_data_in.action = ACT_REFUSE;
            end else begin
               rsp_data_in.action      = ACT_SEND;
               rsp_data_in.out_nonce   = send_next_ff;
               rsp_data_in.out_control = CTL_PSH;
            end
         end else begin
            rsp_data_in.action      = ACT_RESEND;
            rsp_data_in.out_nonce   = send_next_ff - 16'(count_ff) + 16'(rs_idx_ff);
            rsp_data_in.out_control = CTL_PSH;
            rsp_data_in.out_handle  = slot_rdata[SLOT_W-1:TIME_BITS];
         end
         rsp_data_in.window_full   = (EW'(count_in) >= win_eff);
         rsp_data_in.resend_total  = resend_cnt_in;
         rsp_data_in.expired_total = expired_cnt_in;
         rsp_data_in.last          = cmd.last;
      end

      // register writes: to be made only while idle; the block does not enforce it
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_LOCAL_PORT:  local_port_in  = csr_wdata[7:0];
            REG_WINDOW_SIZE: window_size_in = csr_wdata[4:0];
            REG_RESEND_TO:   resend_to_in   = csr_wdata[23:0];
            REG_EXPIRE_TO:   expire_to_in   = csr_wdata[23:0];
            REG_INIT_SEND: begin
               init_send_in = csr_wdata[15:0];
               send_base_in = csr_wdata[15:0];
               send_next_in = csr_wdata[15:0];
               head_in      = '0;
               count_in     = '0;
            end
            REG_INIT_RECV: begin
               init_recv_in = csr_wdata[15:0];
               expected_in  = csr_wdata[15:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LOCAL_PORT:  csr_rdata = CSR_DATA_W'(local_port_ff);
         REG_WINDOW_SIZE: csr_rdata = CSR_DATA_W'(window_size_ff);
         REG_RESEND_TO:   csr_rdata = CSR_DATA_W'(resend_to_ff);
         REG_EXPIRE_TO:   csr_rdata = CSR_DATA_W'(expire_to_ff);
         REG_INIT_SEND:   csr_rdata = CSR_DATA_W'(init_send_ff);
         REG_INIT_RECV:   csr_rdata = CSR_DATA_W'(init_recv_ff);
         default:         csr_rdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_port_ff  <= '0;
         window_size_ff <= WINDOW_SIZE_RST;
         resend_to_ff   <= RESEND_TO_RST;
         expire_to_ff   <= EXPIRE_TO_RST;
         init_send_ff   <= '0;
         init_recv_ff   <= '0;
         now_ff         <= '0;
         send_base_ff   <= '0;
         send_next_ff   <= '0;
         expected_ff    <= '0;
         head_ff        <= '0;
         count_ff       <= '0;
         rs_idx_ff      <= '0;
         resend_cnt_ff  <= '0;
         expired_cnt_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         local_port_ff  <= local_port_in;
         window_size_ff <= window_size_in;
         resend_to_ff   <= resend_to_in;
         expire_to_ff   <= expire_to_in;
         init_send_ff   <= init_send_in;
         init_recv_ff   <= init_recv_in;
         now_ff         <= now_in;
         send_base_ff   <= send_base_in;
         send_next_ff   <= send_next_in;
         expected_ff    <= expected_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         rs_idx_ff      <= rs_idx_in;
         resend_cnt_ff  <= resend_cnt_in;
         expired_cnt_ff <= expired_cnt_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== rtl/go_back_n_arq_link_control.sv =====
// Go-Back-N link control. Pulse start with a request on req_data while busy is
// low: a received header, a user packet handle to send, or a time tick. Each
// result appears on rsp_data for exactly one cycle with rsp_strobe high and
// must be taken then; the receiver cannot stall, and rsp_data.last marks the
// final result of a request. A header yields up to three results. A tick
// pops each expired entry, then, if the oldest entry still held is due for
// resend, resends every held entry. The controller walks the send window
// one slot at a time through the registered-read slot memory.
// Results are registered before they reach the ports, so the next request
// may be accepted while the last result is still being shown. Configuration
// must be written over the APB port only while busy is low; the user is
// bound to this, and the block itself does not enforce it.
`include "go_back_n_arq_link_control_defines.svh"

module go_back_n_arq_link_control
   import gbnl_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_wr_en;

   // zero-wait APB: write lands at the access phase
   assign csr_pready = 1'b1;
   assign csr_wr_en  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // sequence each request through header, send and tick flows
   gbnl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // hold window, counters, registers and the result register
   gbnl_dpath #(
      .WINDOW_MAX (WINDOW_MAX),
      .TIME_BITS  (TIME_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_paddr[CSR_ADDR_W-1:2]),
      .csr_wdata  (csr_pwdata),
      .csr_rdata  (csr_prdata)
   );

   // an accepted request always leaves the controller busy next cycle
   `GBNL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // more results pending means the controller is still working
   `GBNL_ASSERT_IMPLY(a_more_busy, clock, reset, rsp_strobe && !rsp_data.last, busy)
   // a refusal only happens with a full window
   `GBNL_ASSERT_IMPLY(a_refuse_full, clock, reset,
      rsp_strobe && (rsp_data.action == ACT_REFUSE), rsp_data.window_full)

endmodule

// ===== tb/sv/gbnl_link_checker.sv =====
module gbnl_link_checker
   import gbnl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_strobe,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatch_count,
   output int                    pending_count,
   output logic [15:0]           rx_expect,
   output logic [15:0]           tx_base,
   output logic [15:0]           tx_next
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]  port_reg;
   logic [4:0]  win_reg;
   logic [23:0] resend_to;
   logic [23:0] expire_to;

   logic [31:0] now_ticks;
   logic [15:0] send_base, send_next, expected_seq;
   logic [15:0] slot_handle [16];
   logic [31:0] slot_first [16];
   logic [31:0] slot_last [16];
   logic [3:0]  ring_head;
   logic [4:0]  ring_count;
   logic [31:0] resend_cnt, expired_cnt;

   rsp_type link_events [$];
   int      step_results;

   assign pending_count = link_events.size();
   assign rx_expect = expected_seq;
   assign tx_base = send_base;
   assign tx_next = send_next;

   function automatic logic [4:0] window_limit();
      if (win_reg == 0) return 5'd1;
      if (win_reg > 16) return 5'd16;
      return win_reg;
   endfunction

   task automatic push_event(logic [2:0] act, logic [15:0] nonce, logic [7:0] ctl,
                             logic [15:0] handle);
      rsp_type r;
      r.action = act;
      r.out_nonce = nonce;
      r.out_control = ctl;
      r.out_handle = handle;
      r.window_full = (ring_count >= window_limit());
      r.resend_total = resend_cnt;
      r.expired_total = expired_cnt;
      r.last = 1'b0;
      link_events = {link_events, r};
      step_results++;
   endtask

   task automatic model_request(req_type q);
      logic [15:0] diff;
      logic [15:0] first;
      logic [3:0]  idx;
      step_results = 0;
      case (q.command)
         CMD_RX_HDR: begin
            if (q.rx_port == port_reg) begin
               if (q.rx_control & CTL_SYN) expected_seq = q.rx_nonce;
               if (q.rx_control & CTL_PSH) begin
                  if (q.rx_nonce == expected_seq) begin
                     push_event(ACT_DELIVER, q.rx_nonce, 8'h00, 16'h0000);
                     expected_seq = expected_seq + 16'd1;
                  end
                  push_event(ACT_CONTROL, expected_seq, CTL_REQ, 16'h0000);
               end
               if (q.rx_control & CTL_REQ) begin
                  // plain unsigned compare, no wrap
                  if (q.rx_nonce < send_base || q.rx_nonce > send_next) begin
                     push_event(ACT_CONTROL, send_base, CTL_SYN, 16'h0000);
                  end else begin
                     diff = q.rx_nonce - send_base;
                     while (diff > 0 && ring_count > 0) begin
                        ring_head = ring_head + 4'd1;
                        ring_count = ring_count - 5'd1;
                        diff = diff - 16'd1;
                     end
                     send_base = q.rx_nonce;
                  end
               end
            end
         end
         CMD_TX_DATA: begin
            if (ring_count >= window_limit()) begin
               push_event(ACT_REFUSE, 16'h0000, 8'h00, q.tx_handle);
            end else begin
               idx = ring_head + ring_count[3:0];
               slot_handle[idx] = q.tx_handle;
               slot_first[idx] = now_ticks;
               slot_last[idx] = now_ticks;
               ring_count = ring_count + 5'd1;
               send_next = send_next + 16'd1;
               push_event(ACT_SEND, send_next - 16'd1, CTL_PSH, q.tx_handle);
            end
         end
         CMD_TICK: begin
            now_ticks = now_ticks + 32'd1;
            // drop expired entries from the front, silently
            while (ring_count > 0 && (now_ticks - slot_first[ring_head]) > {8'h00, expire_to})
               begin
               ring_head = ring_head + 4'd1;
               ring_count = ring_count - 5'd1;
               send_base = send_base + 16'd1;
               if (expired_cnt != 32'hffff_ffff) expired_cnt = expired_cnt + 32'd1;
            end
            if (ring_count > 0 && (now_ticks - slot_last[ring_head]) > {8'h00, resend_to})
               begin
               first = send_next - {11'd0, ring_count};
               for (int i = 0; i < ring_count; i++) begin
                  idx = ring_head + 4'(i);
                  slot_last[idx] = now_ticks;
                  if (resend_cnt != 32'hffff_ffff) resend_cnt = resend_cnt + 32'd1;
                  push_event(ACT_RESEND, first + 16'(i), CTL_PSH, slot_handle[idx]);
               end
            end
         end
         default: ;
      endcase
      if (step_results > 0) link_events[$].last = 1'b1;
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s expected %0h actual %0h", name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         port_reg = 8'h00; win_reg = WINDOW_SIZE_RST;
         resend_to = RESEND_TO_RST; expire_to = EXPIRE_TO_RST;
         now_ticks = 0; send_base = 0; send_next = 0; expected_seq = 0;
         ring_head = 0; ring_count = 0; resend_cnt = 0; expired_cnt = 0;
         mismatch_count = 0;
         link_events.delete();
      end else begin
         // take the result first: it was formed by an earlier request
         if (rsp_strobe) begin
            if (link_events.size() == 0) begin
               $error("result with nothing expected: action %0d", rsp_data.action);
               mismatch_count++;
            end else begin
               e = link_events[0];
               link_events.delete(0);
               check_field("action", e.action, rsp_data.action);
               check_field("out_nonce", e.out_nonce, rsp_data.out_nonce);
               check_field("out_control", e.out_control, rsp_data.out_control);
               check_field("out_handle", e.out_handle, rsp_data.out_handle);
               check_field("window_full", e.window_full, rsp_data.window_full);
               check_field("resend_total", e.resend_total, rsp_data.resend_total);
               check_field("expired_total", e.expired_total, rsp_data.expired_total);
               check_field("last", e.last, rsp_data.last);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_LOCAL_PORT:  port_reg = csr_pwdata[7:0];
               REG_WINDOW_SIZE: win_reg = csr_pwdata[4:0];
               REG_RESEND_TO:   resend_to = csr_pwdata[23:0];
               REG_EXPIRE_TO:   expire_to = csr_pwdata[23:0];
               REG_INIT_SEND: begin
                  send_base = csr_pwdata[15:0];
                  send_next = csr_pwdata[15:0];
                  ring_head = 0;
                  ring_count = 0;
               end
               REG_INIT_RECV:   expected_seq = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (start && !busy) model_request(req_data);
      end
   end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import gbnl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int mismatch_count, pending_count;
   logic [15:0] rx_expect, tx_base, tx_next;
   int unsigned cycle_count = 0;

   // worst tick: up to 16 expired and 16 resent slots
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 600000;

   go_back_n_arq_link_control uut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   gbnl_link_checker checker_i (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .mismatch_count, .pending_count, .rx_expect, .tx_base, .tx_next
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop if the block hangs or results go missing
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // mostly back to back, sometimes a short pause, rarely a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 45);
   endfunction

   // hold the request until busy drops, then pause at random
   task automatic issue(req_type r);
      int g;
      start = 1'b1;
      req_data = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      g = gap_len();
      if (g > 0) begin
         start = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   // stop sending until all results are in, then let a silent tick finish
   task automatic drain();
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic req_type hdr(logic [7:0] port, logic [15:0] nonce, logic [7:0] ctl);
      req_type r;
      r = '0;
      r.command = CMD_RX_HDR;
      r.rx_port = port;
      r.rx_nonce = nonce;
      r.rx_control = ctl;
      r.tx_handle = 16'($urandom);
      return r;
   endfunction

   function automatic req_type simple_req(logic [1:0] cmd, logic [15:0] handle);
      req_type r;
      r = '0;
      r.command = cmd;
      r.tx_handle = handle;
      r.rx_port = 8'($urandom);
      r.rx_nonce = 16'($urandom);
      r.rx_control = 8'($urandom);
      return r;
   endfunction

   // mostly well formed traffic around the live sequence numbers, some noise
   task automatic random_phase(logic [7:0] port, int count, bit pause_mid);
      int kind;
      logic [7:0] ctl;
      logic [15:0] nonce;
      for (int n = 0; n < count; n++) begin
         if (pause_mid && n == count / 2) drain();
         kind = $urandom_range(0, 99);
         if (kind < 33) begin
            issue(simple_req(CMD_TX_DATA, 16'($urandom)));
         end else if (kind < 63) begin
            issue(simple_req(CMD_TICK, 16'($urandom)));
         end else if (kind < 94) begin
            ctl = 8'($urandom) & 8'hf2;
            if ($urandom_range(0, 2) != 0) ctl = ctl | CTL_PSH;
            if ($urandom_range(0, 1) != 0) ctl = ctl | CTL_REQ;
            if ($urandom_range(0, 5) == 0) ctl = ctl | CTL_SYN;
            case ($urandom_range(0, 5))
               0, 1: nonce = rx_expect + 16'($urandom_range(0, 1));
               2, 3: nonce = tx_base + 16'($urandom_range(0, 4));
               4: nonce = tx_next;
               default: nonce = 16'($urandom);
            endcase
            issue(hdr(port, nonce, ctl));
         end else if (kind < 97) begin
            issue(hdr(port ^ 8'(1 << $urandom_range(0, 7)), 16'($urandom), 8'hff));
         end else begin
            issue(simple_req(CMD_UNUSED, 16'($urandom)));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed pass at the reset settings: port 0, window 4, resend 10
      for (int i = 0; i < 4; i++) issue(simple_req(CMD_TX_DATA, 16'hffff - 16'(i)));
      issue(simple_req(CMD_TX_DATA, 16'h0000));          // window full, refused
      issue(hdr(8'h00, 16'd2, CTL_REQ));                  // ack two entries
      issue(hdr(8'h00, 16'hffff, CTL_REQ));               // out of range, SYN reply
      issue(hdr(8'h00, 16'd0, CTL_PSH));                  // in order, deliver
      issue(hdr(8'h00, 16'd5, CTL_PSH));                  // out of order, REQ only
      issue(hdr(8'h00, 16'hffff, CTL_SYN | CTL_PSH | CTL_REQ));
      issue(hdr(8'h00, 16'h1234, 8'hf2));                 // no flag set
      issue(hdr(8'hff, 16'd0, 8'hff));                    // other port
      issue(simple_req(CMD_UNUSED, 16'h5555));            // unknown command
      for (int i = 0; i < 12; i++) issue(simple_req(CMD_TICK, 16'haaaa));
      drain();

      // wrap of sequence numbers, widest window, quick timers
      csr_write(REG_LOCAL_PORT, 32'hffff_ffff);
      csr_write(REG_WINDOW_SIZE, 32'd16);
      csr_write(REG_RESEND_TO, 32'd1);
      csr_write(REG_EXPIRE_TO, 32'd3);
      csr_write(REG_INIT_SEND, 32'h0000_fffe);
      csr_write(REG_INIT_RECV, 32'h0000_ffff);
      random_phase(8'hff, 64, 1'b1);
      drain();

      // single slot window, timers at their maximum
      csr_write(REG_LOCAL_PORT, 32'h5a);
      csr_write(REG_WINDOW_SIZE, 32'd1);
      csr_write(REG_RESEND_TO, 32'h00ff_ffff);
      csr_write(REG_EXPIRE_TO, 32'h00ff_ffff);
      csr_write(REG_INIT_SEND, 32'd0);
      csr_write(REG_INIT_RECV, 32'd0);
      random_phase(8'h5a, 48, 1'b0);
      drain();

      // window size zero acts as one
      csr_write(REG_LOCAL_PORT, 32'h00);
      csr_write(REG_WINDOW_SIZE, 32'd0);
      csr_write(REG_RESEND_TO, 32'd5);
      csr_write(REG_EXPIRE_TO, 32'd30);
      random_phase(8'h00, 48, 1'b0);
      drain();

      // oversized window acts as the maximum; leave entries held afterwards
      csr_write(REG_WINDOW_SIZE, 32'd31);
      csr_write(REG_RESEND_TO, 32'd2);
      csr_write(REG_EXPIRE_TO, 32'd12);
      csr_write(REG_INIT_SEND, 32'h8000);
      random_phase(8'h00, 64, 1'b0);
      for (int i = 0; i < 16; i++) issue(simple_req(CMD_TX_DATA, 16'($urandom)));
      drain();

      // shrink the window over held entries, random timers
      csr_write(REG_WINDOW_SIZE, 32'd3);
      csr_write(REG_RESEND_TO, 32'($urandom_range(1, 8)));
      csr_write(REG_EXPIRE_TO, 32'($urandom_range(5, 40)));
      csr_write(REG_INIT_RECV, 32'($urandom_range(0, 65535)));
      random_phase(8'h00, 56, 1'b0);
      drain();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
